/* src/bso_pkg.sv */
`default_nettype none

package bso_pkg;

  localparam int ELEM_W   = 32;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 3'd0,
    CMD_ADD_A = 3'd1,
    CMD_ADD_B = 3'd2,
    CMD_UNION = 3'd3,
    CMD_INTER = 3'd4,
    CMD_DIFF  = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_TRUNC = 2'd2
  } status_t;

  // Sequencer states of the query engine.
  typedef enum logic [2:0] {
    S_IDLE,
    S_OREAD,
    S_OWAIT,
    S_SCAN,
    S_DECIDE,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

/* src/bso_req_if.sv */
`default_nettype none

interface bso_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [bso_pkg::CMD_W-1:0]            cmd;
  logic signed [bso_pkg::ELEM_W-1:0]    value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

`default_nettype wire

/* src/bso_rsp_if.sv */
`default_nettype none

interface bso_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bso_pkg::ELEM_W-1:0]    element;
  logic                                 has_element;
  logic                                 last;
  logic [bso_pkg::STATUS_W-1:0]         status;

  modport source (output valid, output element, output has_element, output last,
                  output status, input ready);
  modport sink   (input valid, input element, input has_element, input last,
                  input status, output ready);
endinterface

`default_nettype wire

/* src/bounded_set_operations_top.sv */
`default_nettype none

// Bounded set operations over two lists A and B of signed 32-bit words, each
// holding up to SET_SIZE entries in its own on-chip memory. A request carries a
// command: clear both lists, append a value to A or B (duplicates are kept, a
// full list refuses with status FULL), or query the union, intersection or
// difference A minus B. Every request except an unknown command (codes 6 and 7,
// which are dropped silently) produces one or more responses; the final one has
// last set. Clear, append and an empty query give a single response with
// has_element low. A union longer than SET_SIZE is cut to its first SET_SIZE
// elements and the final response carries status TRUNC. The block handles one
// request at a time. Clear and append complete in the cycle that accepts them.
// A query walks an outer list and, for each outer element, reads it, waits for
// the registered read data, scans the inner list (none in the first pass of a
// union) one word per cycle through the memory read port, stopping at the first
// match, and then decides whether to keep it. A query also accepts the request,
// makes a closing read of the outer index and writes the final response, and a
// union switches from A to B between its passes. The worst case from one
// accepted request to the next is a union of two full lists where every element
// of B matches only the last word of A, with the response side always ready.
// Responses leave through an output register, and one further found element is
// held back in a pending register until it is known whether it closes the
// result. The scan stalls only when it keeps a new element while both the output
// register and the pending register are still occupied. The lists are written
// only while the block is idle and their read data is used only during a query,
// so no used read can meet a write to the same entry. List contents are
// undefined after reset; of the lists, only the counts are cleared.
module bounded_set_operations_top #(
  parameter int SET_SIZE = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  bso_req_if.sink   req,
  bso_rsp_if.source rsp
);

  import bso_pkg::*;

  localparam int AW = $clog2(SET_SIZE);
  localparam int CW = $clog2(SET_SIZE + 1);

  // Control state.
  state_t           state, state_next;
  logic [CW-1:0]    count_a, count_a_next;
  logic [CW-1:0]    count_b, count_b_next;
  logic             pend_v, pend_v_next;
  logic             out_valid, out_valid_next;

  // Working registers of the query engine.
  logic [CW-1:0]             oi, oi_next;          // outer index
  logic [AW-1:0]             ij, ij_next;          // inner index
  logic [CW-1:0]             n, n_next;            // elements found so far
  logic signed [ELEM_W-1:0]  outer_val, outer_val_next;
  logic signed [ELEM_W-1:0]  pend, pend_next;      // found element not yet sent
  logic                      keep_r, keep_r_next;
  logic                      outer_b, outer_b_next;       // outer list is B
  logic                      union_first, union_first_next;
  logic                      inner_none, inner_none_next; // no inner scan
  logic                      keep_found, keep_found_next; // keep on a match

  // Output register.
  logic signed [ELEM_W-1:0]  out_elem, out_elem_next;
  logic                      out_has, out_has_next;
  logic                      out_last, out_last_next;
  status_t                   out_status, out_status_next;

  // Memory ports.
  logic                      we_a, we_b;
  logic [AW-1:0]             raddr_a, raddr_b;
  logic [ELEM_W-1:0]         rdata_a, rdata_b;

  // Combinational helpers.
  logic [CW-1:0]             outer_cnt, inner_cnt, ij_inc;
  logic                      o_more, i_more, slot_free, match;
  logic [AW-1:0]             outer_addr, inner_addr;
  logic signed [ELEM_W-1:0]  outer_data, inner_data;
  logic                      emit, emit_has, emit_last;
  logic signed [ELEM_W-1:0]  emit_elem;
  status_t                   emit_status;

  bso_ram #(.DEPTH(SET_SIZE), .WIDTH(ELEM_W)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (count_a[AW-1:0]),
    .wdata (req.value),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  bso_ram #(.DEPTH(SET_SIZE), .WIDTH(ELEM_W)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (count_b[AW-1:0]),
    .wdata (req.value),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // The outer and inner lists always sit in different memories, so each
  // memory sees at most one read per cycle.
  assign outer_cnt  = outer_b ? count_b : count_a;
  assign inner_cnt  = inner_none ? '0 : (outer_b ? count_a : count_b);
  assign outer_data = outer_b ? rdata_b : rdata_a;
  assign inner_data = outer_b ? rdata_a : rdata_b;
  assign ij_inc     = CW'(ij) + CW'(1);
  assign o_more     = oi < outer_cnt;
  assign i_more     = ij_inc < inner_cnt;
  assign match      = inner_data == outer_val;
  assign slot_free  = !out_valid || rsp.ready;

  assign outer_addr = o_more ? oi[AW-1:0] : '0;
  assign inner_addr = (state == S_SCAN && i_more) ? ij + AW'(1) : '0;
  assign raddr_a    = outer_b ? inner_addr : outer_addr;
  assign raddr_b    = outer_b ? outer_addr : inner_addr;

  assign req.ready       = (state == S_IDLE) && slot_free;
  assign rsp.valid       = out_valid;
  assign rsp.element     = out_elem;
  assign rsp.has_element = out_has;
  assign rsp.last        = out_last;
  assign rsp.status      = out_status;

  always_comb begin
    state_next       = state;
    count_a_next     = count_a;
    count_b_next     = count_b;
    pend_v_next      = pend_v;
    oi_next          = oi;
    ij_next          = ij;
    n_next           = n;
    outer_val_next   = outer_val;
    pend_next        = pend;
    keep_r_next      = keep_r;
    outer_b_next     = outer_b;
    union_first_next = union_first;
    inner_none_next  = inner_none;
    keep_found_next  = keep_found;
    we_a             = 1'b0;
    we_b             = 1'b0;
    emit             = 1'b0;
    emit_elem        = '0;
    emit_has         = 1'b0;
    emit_last        = 1'b1;
    emit_status      = ST_OK;

    case (state)
      S_IDLE: begin
        if (req.valid && req.ready) begin
          oi_next          = '0;
          n_next           = '0;
          pend_v_next      = 1'b0;
          union_first_next = 1'b0;
          inner_none_next  = 1'b0;
          keep_found_next  = 1'b0;
          outer_b_next     = 1'b0;
          case (req.cmd)
            CMD_CLEAR: begin
              count_a_next = '0;
              count_b_next = '0;
              emit         = 1'b1;
            end
            CMD_ADD_A: begin
              emit = 1'b1;
              if (count_a < CW'(SET_SIZE)) begin
                we_a         = 1'b1;
                count_a_next = count_a + CW'(1);
              end else begin
                emit_status = ST_FULL;
              end
            end
            CMD_ADD_B: begin
              emit = 1'b1;
              if (count_b < CW'(SET_SIZE)) begin
                we_b         = 1'b1;
                count_b_next = count_b + CW'(1);
              end else begin
                emit_status = ST_FULL;
              end
            end
            CMD_UNION: begin
              // First pass copies A (no inner scan), second pass keeps B
              // elements missing from A.
              union_first_next = 1'b1;
              inner_none_next  = 1'b1;
              state_next       = S_OREAD;
            end
            CMD_INTER: begin
              outer_b_next    = !(count_a > count_b);
              keep_found_next = 1'b1;
              state_next      = S_OREAD;
            end
            CMD_DIFF: begin
              state_next = S_OREAD;
            end
            default: begin
            end
          endcase
        end
      end

      S_OREAD: begin
        if (o_more) begin
          state_next = S_OWAIT;
        end else if (union_first) begin
          union_first_next = 1'b0;
          inner_none_next  = 1'b0;
          outer_b_next     = 1'b1;
          oi_next          = '0;
        end else begin
          state_next = S_FINISH;
        end
      end

      S_OWAIT: begin
        outer_val_next = outer_data;
        ij_next        = '0;
        if (inner_cnt == '0) begin
          keep_r_next = !keep_found;
          state_next  = S_DECIDE;
        end else begin
          state_next = S_SCAN;
        end
      end

      S_SCAN: begin
        if (match) begin
          keep_r_next = keep_found;
          state_next  = S_DECIDE;
        end else if (i_more) begin
          ij_next = ij + AW'(1);
        end else begin
          keep_r_next = !keep_found;
          state_next  = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (!(keep_r && pend_v && !slot_free)) begin
          if (keep_r && pend_v && n == CW'(SET_SIZE)) begin
            // One more element than fits: the held one closes the result.
            emit        = 1'b1;
            emit_elem   = pend;
            emit_has    = 1'b1;
            emit_status = ST_TRUNC;
            pend_v_next = 1'b0;
            state_next  = S_IDLE;
          end else begin
            if (keep_r) begin
              if (pend_v) begin
                emit      = 1'b1;
                emit_elem = pend;
                emit_has  = 1'b1;
                emit_last = 1'b0;
              end
              pend_next   = outer_val;
              pend_v_next = 1'b1;
              n_next      = n + CW'(1);
            end
            oi_next    = oi + CW'(1);
            state_next = S_OREAD;
          end
        end
      end

      S_FINISH: begin
        if (slot_free) begin
          emit        = 1'b1;
          emit_elem   = pend_v ? pend : '0;
          emit_has    = pend_v;
          pend_v_next = 1'b0;
          state_next  = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next  = out_valid;
    out_elem_next   = out_elem;
    out_has_next    = out_has;
    out_last_next   = out_last;
    out_status_next = out_status;
    if (emit) begin
      out_valid_next  = 1'b1;
      out_elem_next   = emit_elem;
      out_has_next    = emit_has;
      out_last_next   = emit_last;
      out_status_next = emit_status;
    end else if (rsp.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count_a   <= '0;
      count_b   <= '0;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count_a   <= count_a_next;
      count_b   <= count_b_next;
      pend_v    <= pend_v_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    oi          <= oi_next;
    ij          <= ij_next;
    n           <= n_next;
    outer_val   <= outer_val_next;
    pend        <= pend_next;
    keep_r      <= keep_r_next;
    outer_b     <= outer_b_next;
    union_first <= union_first_next;
    inner_none  <= inner_none_next;
    keep_found  <= keep_found_next;
    out_elem    <= out_elem_next;
    out_has     <= out_has_next;
    out_last    <= out_last_next;
    out_status  <= out_status_next;
  end

endmodule

`default_nettype wire

/* src/bso_ram.sv */
`default_nettype none

// Single-port-write, single-port-read memory with a registered read.
module bso_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/bso_checker.sv */
`default_nettype none

module bso_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               req_valid,
  input wire logic                               req_ready,
  input wire logic [bso_pkg::CMD_W-1:0]          req_cmd,
  input wire logic                               rsp_valid,
  input wire logic                               rsp_ready,
  input wire logic signed [bso_pkg::ELEM_W-1:0]  rsp_element,
  input wire logic                               rsp_has_element,
  input wire logic                               rsp_last,
  input wire logic [bso_pkg::STATUS_W-1:0]       rsp_status
);

  import bso_pkg::*;

  // A stalled response keeps its contents.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_element)
      && $stable(rsp_has_element) && $stable(rsp_last) && $stable(rsp_status))
    else $error("response changed while stalled");

  // A response without an element is always a single, final one, with zero data.
  a_no_elem: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_has_element |-> rsp_last && rsp_element == '0)
    else $error("empty response not final or carries data");

  // Truncation is reported only on the final element of a result.
  a_trunc: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_TRUNC |-> rsp_has_element && rsp_last)
    else $error("truncation status on a non-final or empty response");

  // A clear is acknowledged in the next cycle with a plain final response.
  a_clear_ack: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_cmd == CMD_CLEAR |=>
      rsp_valid && !rsp_has_element && rsp_last && rsp_status == ST_OK)
    else $error("clear not acknowledged");

endmodule

bind bounded_set_operations_top bso_checker u_bso_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .req_cmd         (req.cmd),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_element     (rsp.element),
  .rsp_has_element (rsp.has_element),
  .rsp_last        (rsp.last),
  .rsp_status      (rsp.status)
);

`default_nettype wire
